>>> sv/imu_complementary_tilt_filter_core_macros.svh
// Assertion macros for the complementary tilt filter.
// Used by the top level only; the bodies refer to its clk and arst_n.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_CORE_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTFL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTFL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ctfl_pkg.sv
// Shared types and constants of the complementary tilt filter.
// No dependencies; every module file imports it.
package ctfl_pkg;

	localparam int IDX_W      = 5;   // step index, up to 32 CORDIC steps
	localparam int SQ_W       = 48;  // square root radicand and work registers
	localparam int ROOT_W     = 24;  // bits of the square root result
	localparam int ROOT_STEPS = 24;  // one result bit per step
	localparam int IW         = 28;  // CORDIC operand before the 256 prescale
	localparam int CW         = 36;  // CORDIC x and y registers
	localparam int ZW         = 32;  // Q4.28 angle

	localparam logic [16:0] ALPHA_ONE   = 17'd65536;
	localparam logic [16:0] ALPHA_RESET = 17'd64225;
	localparam logic signed [ZW-1:0] PI_Q28 = 32'sd843314857;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic        [15:0] step_time;
	} ctfl_sample_t;

	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] lateral_roll_angle;
		logic signed [15:0] heading_angle;
	} ctfl_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROOT,
		ST_PLOAD,
		ST_PROT,
		ST_DIFF,
		ST_MUL,
		ST_FIN
	} ctfl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             capture;
		logic             prep;
		logic             root_step;
		logic             rot_step;
		logic             load_pitch;
		logic             keep_roll;
		logic             diff;
		logic             mul;
		logic             commit;
		logic [IDX_W-1:0] idx;
	} ctfl_cmd_t;

	// Arctangent of 2^-i in Q4.28.
	function automatic logic signed [ZW-1:0] ctfl_atan(input logic [IDX_W-1:0] i);
		logic signed [ZW-1:0] v;
		unique case (i)
			5'd0:  v = 32'sd210828714;
			5'd1:  v = 32'sd124459457;
			5'd2:  v = 32'sd65760959;
			5'd3:  v = 32'sd33381290;
			5'd4:  v = 32'sd16755422;
			5'd5:  v = 32'sd8385879;
			5'd6:  v = 32'sd4193963;
			5'd7:  v = 32'sd2097109;
			5'd8:  v = 32'sd1048571;
			5'd9:  v = 32'sd524287;
			5'd10: v = 32'sd262144;
			5'd11: v = 32'sd131072;
			5'd12: v = 32'sd65536;
			5'd13: v = 32'sd32768;
			5'd14: v = 32'sd16384;
			5'd15: v = 32'sd8192;
			5'd16: v = 32'sd4096;
			5'd17: v = 32'sd2048;
			5'd18: v = 32'sd1024;
			5'd19: v = 32'sd512;
			5'd20: v = 32'sd256;
			5'd21: v = 32'sd128;
			5'd22: v = 32'sd64;
			5'd23: v = 32'sd32;
			5'd24: v = 32'sd16;
			5'd25: v = 32'sd8;
			5'd26: v = 32'sd4;
			5'd27: v = 32'sd2;
			5'd28: v = 32'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> sv/ctfl_sqrt.sv
// Bit-serial integer square root, two radicand bits per step.
// Depends on ctfl_pkg for widths.
module ctfl_sqrt import ctfl_pkg::*; (
	input  logic              clk,
	input  logic              load,
	input  logic              step,
	input  logic [SQ_W-1:0]   radicand,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] n_q, r_q, bit_q;
	logic [SQ_W-1:0] trial;

	assign trial = r_q + bit_q;
	assign root  = r_q[ROOT_W-1:0];

	// Restoring square root; the probe bit walks down from bit 46.
	always_ff @(posedge clk) begin
		if (load) begin
			n_q   <= radicand;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (step) begin
			if (n_q >= trial) begin
				n_q <= n_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

>>> sv/ctfl_cordic.sv
// CORDIC vectoring unit, one micro-rotation per step, angle in Q4.28.
// Depends on ctfl_pkg for widths, pi and the arctangent table.
module ctfl_cordic import ctfl_pkg::*; (
	input  logic                 clk,
	input  logic                 load,
	input  logic                 step,
	input  logic [IDX_W-1:0]     idx,
	input  logic signed [IW-1:0] y0,
	input  logic signed [IW-1:0] x0,
	output logic signed [ZW-1:0] angle
);

	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q, base_q;
	logic                 zero_q;
	logic                 neg;
	logic signed [IW-1:0] xn, yn;
	logic signed [ZW-1:0] base;
	logic signed [CW-1:0] xs, ys;
	logic signed [ZW-1:0] atn;

	// Fold a left half-plane vector into the right half-plane.
	always_comb begin
		neg = x0 < 0;
		xn  = neg ? -x0 : x0;
		yn  = neg ? -y0 : y0;
		if (!neg) begin
			base = '0;
		end else if (yn <= 0) begin
			base = PI_Q28;
		end else begin
			base = -PI_Q28;
		end
	end

	assign xs  = x_q >>> idx;
	assign ys  = y_q >>> idx;
	assign atn = ctfl_atan(idx);

	// Drive y toward zero and accumulate the rotated angle.
	always_ff @(posedge clk) begin
		if (load) begin
			x_q    <= CW'(xn) <<< 8;
			y_q    <= CW'(yn) <<< 8;
			z_q    <= '0;
			base_q <= base;
			zero_q <= (x0 == 0) && (y0 == 0);
		end else if (step) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atn;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atn;
			end
		end
	end

	assign angle = zero_q ? '0 : base_q + z_q;

endmodule

>>> sv/ctfl_dp.sv
// Datapath of the tilt filter: sample and blend registers, angle stores, result.
// Depends on ctfl_pkg, ctfl_sqrt and ctfl_cordic.
module ctfl_dp import ctfl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  ctfl_cmd_t    cmd,
	input  ctfl_sample_t sample,
	input  logic         blend_alpha_we,
	input  logic [16:0]  blend_alpha_wdata,
	output ctfl_result_t result
);

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		if (v > 38'sd2147483647) return 32'sh7fffffff;
		if (v < -38'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) return 16'sh7fff;
		if (v < -18'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	ctfl_sample_t         smp_q;
	logic [16:0]          alpha_q;
	logic [16:0]          alpha_eff;
	logic signed [32:0]   gp_q, gr_q, gh_q;
	logic signed [ZW-1:0] roll_tilt_q, acc_p_q, acc_r_q;
	logic signed [34:0]   dp_q, dr_q;
	logic signed [52:0]   mp_q, mr_q;
	logic signed [31:0]   pitch_q, roll_q;
	logic [31:0]          head_q;
	ctfl_result_t         res_q;

	logic signed [16:0]   up, left, dt17;
	logic signed [33:0]   up2, left2;
	logic [31:0]          sum2;
	logic [ROOT_W-1:0]    root;
	logic signed [IW-1:0] cy0, cx0;
	logic signed [ZW-1:0] angle;
	logic signed [33:0]   pred_p, pred_r;
	logic signed [17:0]   a_s;
	logic signed [36:0]   tp, tr;
	logic signed [31:0]   new_p, new_r;
	logic signed [32:0]   hinc;
	logic [31:0]          new_h, hsum;

	// Body frame axes and the squared horizontal magnitude.
	always_comb begin
		up    = -17'(smp_q.accel_x);
		left  = -17'(smp_q.accel_y);
		dt17  = signed'({1'b0, smp_q.step_time});
		up2   = up * up;
		left2 = left * left;
		sum2  = up2[31:0] + left2[31:0];
	end

	ctfl_sqrt u_sqrt (
		.clk      (clk),
		.load     (cmd.prep),
		.step     (cmd.root_step),
		.radicand ({sum2, 16'b0}),
		.root     (root)
	);

	// Roll operands go in at prep, pitch operands after the root is done.
	always_comb begin
		if (cmd.load_pitch) begin
			cy0 = IW'(smp_q.accel_z) <<< 8;
			cx0 = IW'(signed'({1'b0, root}));
		end else begin
			cy0 = IW'(left) <<< 8;
			cx0 = IW'(up) <<< 8;
		end
	end

	ctfl_cordic u_cordic (
		.clk   (clk),
		.load  (cmd.prep || cmd.load_pitch),
		.step  (cmd.rot_step),
		.idx   (cmd.idx),
		.y0    (cy0),
		.x0    (cx0),
		.angle (angle)
	);

	// Gyro weight register; values above one act as one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (blend_alpha_we) begin
			alpha_q <= blend_alpha_wdata;
		end
	end

	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign a_s       = signed'({1'b0, alpha_eff});

	// Prediction minus accelerometer angle, scaled by alpha.
	always_comb begin
		pred_p = 34'(pitch_q) - 34'(gp_q);
		pred_r = 34'(roll_q) + 34'(gr_q);
		tp     = 37'((mp_q + 53'sd32768) >>> 16);
		tr     = 37'((mr_q + 53'sd32768) >>> 16);
		new_p  = sat32(38'(acc_p_q) + 38'(tp));
		new_r  = sat32(38'(acc_r_q) + 38'(tr));
		hinc   = (gh_q + 33'sd8) >>> 4;
		new_h  = head_q + hinc[31:0];
		hsum   = new_h + 32'd32768;
	end

	// Working registers of one sample.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_q <= sample;
		end
		if (cmd.prep) begin
			gp_q <= smp_q.gyro_y * dt17;
			gr_q <= smp_q.gyro_z * dt17;
			gh_q <= smp_q.gyro_x * dt17;
		end
		if (cmd.keep_roll) begin
			roll_tilt_q <= angle;
		end
		if (cmd.diff) begin
			acc_p_q <= angle;
			acc_r_q <= roll_tilt_q;
			dp_q    <= 35'(pred_p) - 35'(angle);
			dr_q    <= 35'(pred_r) - 35'(roll_tilt_q);
		end
		if (cmd.mul) begin
			mp_q <= a_s * dp_q;
			mr_q <= a_s * dr_q;
		end
		if (cmd.commit) begin
			res_q.pitch_angle        <= sat16(18'((33'(new_p) + 33'sd16384) >>> 15));
			res_q.lateral_roll_angle <= sat16(18'((33'(new_r) + 33'sd16384) >>> 15));
			res_q.heading_angle      <= hsum[31:16];
		end
	end

	// Filter state: fused angles and heading.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= '0;
			roll_q  <= '0;
			head_q  <= '0;
		end else if (cmd.commit) begin
			pitch_q <= new_p;
			roll_q  <= new_r;
			head_q  <= new_h;
		end
	end

	assign result = res_q;

endmodule

>>> sv/ctfl_ctrl.sv
// Controller of the tilt filter: sequences one sample through the datapath.
// Depends on ctfl_pkg for the state and command types.
module ctfl_ctrl import ctfl_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_ready,
	output logic      result_valid,
	input  logic      result_ready,
	output ctfl_cmd_t cmd
);

	localparam int LOOP_N = (CORDIC_STEPS > ROOT_STEPS) ? CORDIC_STEPS : ROOT_STEPS;

	ctfl_state_t      state_q, state_d;
	logic [IDX_W-1:0] step_q;
	logic             valid_q;
	logic             commit;
	logic             last_loop, last_rot;

	assign last_loop = step_q == IDX_W'(LOOP_N - 1);
	assign last_rot  = step_q == IDX_W'(CORDIC_STEPS - 1);
	assign commit    = (state_q == ST_FIN) && (!valid_q || result_ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (sample_valid) state_d = ST_PREP;
			ST_PREP:  state_d = ST_ROOT;
			ST_ROOT:  if (last_loop) state_d = ST_PLOAD;
			ST_PLOAD: state_d = ST_PROT;
			ST_PROT:  if (last_rot) state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_FIN;
			ST_FIN:   if (commit) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd            = '0;
		cmd.idx        = step_q;
		cmd.capture    = (state_q == ST_IDLE) && sample_valid;
		cmd.prep       = state_q == ST_PREP;
		cmd.root_step  = (state_q == ST_ROOT) && (step_q < IDX_W'(ROOT_STEPS));
		cmd.rot_step   = ((state_q == ST_ROOT) && (step_q < IDX_W'(CORDIC_STEPS)))
			|| (state_q == ST_PROT);
		cmd.load_pitch = state_q == ST_PLOAD;
		cmd.keep_roll  = state_q == ST_PLOAD;
		cmd.diff       = state_q == ST_DIFF;
		cmd.mul        = state_q == ST_MUL;
		cmd.commit     = commit;
	end

	// State, loop counter and result beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_ROOT) || (state_q == ST_PROT)) begin
				step_q <= (state_d == state_q) ? step_q + 1'b1 : '0;
			end else begin
				step_q <= '0;
			end
			if (commit) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign sample_ready = state_q == ST_IDLE;
	assign result_valid = valid_q;

endmodule

>>> sv/imu_complementary_tilt_filter_core.sv
// IMU complementary tilt filter: one sample beat in, one fused attitude beat out.
// After a sample beat is accepted the block steps through prep, root, pitch load, pitch
// rotation, difference, multiply and finish before ready rises again, so it takes no new
// sample until it is through with the last one. The sequence length is set by the single
// shared CORDIC unit, which resolves roll while the bit-serial square root runs and then
// resolves pitch; the finish state stretches while an earlier result beat still waits.
// The result register lets the next sample be taken while a result beat waits. Writing
// blend_alpha (Q1.16 gyro weight, values above one act as one) is allowed only while
// the block is idle.
`include "imu_complementary_tilt_filter_core_macros.svh"

module imu_complementary_tilt_filter_core import ctfl_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         sample_valid,
	output logic         sample_ready,
	input  ctfl_sample_t sample,
	output logic         result_valid,
	input  logic         result_ready,
	output ctfl_result_t result,
	input  logic         blend_alpha_we,
	input  logic [16:0]  blend_alpha_wdata
);

	ctfl_cmd_t cmd;

	ctfl_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd)
	);

	ctfl_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sample            (sample),
		.blend_alpha_we    (blend_alpha_we),
		.blend_alpha_wdata (blend_alpha_wdata),
		.result            (result)
	);

	// A sample beat starts the sequence, so the block is busy right after it.
	`CTFL_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready, "ready after accept")
	// A new result only appears at the end of a sequence, never while idle.
	`CTFL_ASSERT_SAME(a_result_from_work, $rose(result_valid), $past(!sample_ready), "result without work")
	// A commit loads the result register, so a beat is offered next cycle.
	`CTFL_ASSERT_NEXT(a_commit_shows, cmd.commit, result_valid, "commit lost")

endmodule
